@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, masked while reset is asserted.
`define RDT_ASSERT(lbl, CLK, RSTN, prop, msg) \
  lbl: assert property (@(posedge CLK) disable iff (!RSTN) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define RDT_ASSERT_ALWAYS(lbl, CLK, prop, msg) \
  lbl: assert property (@(posedge CLK) prop) else $error(msg);

`endif

@@ hw/rtl/rdt_pkg.sv @@
package rdt_pkg;

  localparam int CfgAw     = 6;
  localparam int CfgDw     = 64;
  localparam int RegIdxW   = 3;

  localparam logic [RegIdxW-1:0] REG_ROT0  = 3'd0;
  localparam logic [RegIdxW-1:0] REG_ROT1  = 3'd1;
  localparam logic [RegIdxW-1:0] REG_ROT2  = 3'd2;
  localparam logic [RegIdxW-1:0] REG_TRANS = 3'd3;
  localparam logic [RegIdxW-1:0] REG_THR   = 3'd4;

  localparam logic [47:0] ROT0_RST  = 48'h0000_8000_0000;
  localparam logic [47:0] ROT1_RST  = 48'h0000_0000_8000;
  localparam logic [47:0] ROT2_RST  = 48'h8000_0000_0000;
  localparam logic [31:0] THR_RST   = 32'd4295;

  localparam int NW        = 56;   // |numerator|, Q.40
  localparam int DW        = 49;   // determinant, Q.40, positive when used
  localparam int QW        = 32;   // Q16.16 depth
  localparam int DepthFrac = 16;
  localparam int DivSteps  = 2;    // quotient bits per divider stage
  localparam int DivStages = QW / DivSteps;

  typedef struct packed {
    logic [47:0] rot0;
    logic [47:0] rot1;
    logic [47:0] rot2;
    logic [59:0] trans;
    logic [31:0] thr;
  } cfg_t;

  // front end -> divider
  typedef struct packed {
    logic          valid;
    logic          reject;
    logic [NW-1:0] n;
    logic [DW-1:0] d;
  } front_out_t;

  typedef struct packed {
    logic          reject;
    logic          sat;
    logic [DW-1:0] r;
    logic [QW-1:0] nl;
    logic [QW-1:0] q;
    logic [DW-1:0] d;
  } div_st_t;

  // DivSteps restoring long-division steps
  function automatic div_st_t div_step(div_st_t s);
    div_st_t       o;
    logic [DW:0]   rr;
    logic          ge;
    o = s;
    for (int k = 0; k < DivSteps; k++) begin
      rr   = {o.r, o.nl[QW-1]};
      o.nl = {o.nl[QW-2:0], 1'b0};
      ge   = (rr >= {1'b0, o.d});
      o.r  = ge ? DW'(rr - {1'b0, o.d}) : rr[DW-1:0];
      o.q  = {o.q[QW-2:0], ge};
    end
    return o;
  endfunction

endpackage

@@ hw/rtl/two_ray_depth_triangulation.sv @@
// Two-view depth triangulation. Each transaction on in_ carries a reference
// and a current bearing (six Q1.15 components); the block rotates the
// reference bearing by the programmed rotation, builds the 2x2 normal matrix
// of the two rays and returns one transaction on out_ per input: the Q16.16
// depth along the reference ray (truncated, saturated to all ones) in
// out_tdata and an accept flag in out_tuser. A pair whose determinant is not
// positive or lies below det_threshold*2^8 comes back with flag 0 and depth 0.
// Throughput is one pair per clock while the skid entry is empty. A pair
// passes six arithmetic stages (rotate, round, dot terms, dot sums, 2x2
// products, determinant/compare), one divider setup stage, a restoring
// divider of 16 stages retiring two quotient bits each, then the
// output register. A two-entry skid at the output keeps in_tready registered.
// Registers (APB, 64-bit data, byte address 8*i): rotation_row0..2,
// translation_packed, det_threshold; write only while the block is idle.
module two_ray_depth_triangulation import rdt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  // in_tdata: ref_x, ref_y, ref_z, cur_x, cur_y, cur_z (16 bits each, low up)
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [95:0]      in_tdata,
  // out_tdata: depth_out[31:0]
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [31:0]      out_tdata,
  // out_tuser: valid_res
  output logic             out_tuser,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [CfgAw-1:0] paddr,
  input  logic [CfgDw-1:0] pwdata,
  output logic [CfgDw-1:0] prdata,
  output logic             pready
);

  cfg_t          cfg;
  front_out_t    fo;
  logic          en;
  logic          res_v, res_ok;
  logic [QW-1:0] res_depth;

  logic          out_v_r, skid_v_r;
  logic [QW-1:0] out_d_r, skid_d_r;
  logic          out_u_r, skid_u_r;

  // whole pipeline moves together; it halts only while the skid entry is full
  assign en        = !skid_v_r;
  assign in_tready = en;

  rdt_regs u_regs (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg
  );

  rdt_front u_front (
    .clk, .rst_n, .en,
    .in_v    (in_tvalid),
    .in_data (in_tdata),
    .cfg,
    .fo
  );

  rdt_div u_div (
    .clk, .rst_n, .en, .fo,
    .res_v, .res_depth, .res_ok
  );

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_tready) begin
        skid_v_r <= 1'b0;
      end
    end else if (res_v) begin
      if (out_v_r && !out_tready) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_tready) begin
        out_d_r <= skid_d_r;
        out_u_r <= skid_u_r;
      end
    end else if (res_v) begin
      if (out_v_r && !out_tready) begin
        skid_d_r <= res_depth;
        skid_u_r <= res_ok;
      end else begin
        out_d_r <= res_depth;
        out_u_r <= res_ok;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_tuser  = out_u_r;

endmodule

@@ hw/rtl/rdt_regs.sv @@
module rdt_regs import rdt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [CfgAw-1:0] paddr,
  input  logic [CfgDw-1:0] pwdata,
  output logic [CfgDw-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  cfg_t              cfg_r;
  logic              wr_en;
  logic [RegIdxW-1:0] idx;

  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[CfgAw-1:3];
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rot0  <= ROT0_RST;
      cfg_r.rot1  <= ROT1_RST;
      cfg_r.rot2  <= ROT2_RST;
      cfg_r.trans <= '0;
      cfg_r.thr   <= THR_RST;
    end else if (wr_en) begin
      case (idx)
        REG_ROT0:  cfg_r.rot0  <= pwdata[47:0];
        REG_ROT1:  cfg_r.rot1  <= pwdata[47:0];
        REG_ROT2:  cfg_r.rot2  <= pwdata[47:0];
        REG_TRANS: cfg_r.trans <= pwdata[59:0];
        REG_THR:   cfg_r.thr   <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ROT0:  prdata = {16'b0, cfg_r.rot0};
      REG_ROT1:  prdata = {16'b0, cfg_r.rot1};
      REG_ROT2:  prdata = {16'b0, cfg_r.rot2};
      REG_TRANS: prdata = {4'b0, cfg_r.trans};
      REG_THR:   prdata = {32'b0, cfg_r.thr};
      default:   prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/rdt_front.sv @@
module rdt_front import rdt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_v,
  input  logic [95:0] in_data,
  input  cfg_t        cfg,
  output front_out_t  fo
);

  logic [5:0] v_r;

  // S1: rotation products
  logic signed [31:0] pr_r [3][3];
  logic signed [15:0] b1_r [3];
  // S2: rotated bearing
  logic signed [17:0] a_r  [3];
  logic signed [15:0] b2_r [3];
  // S3: dot-product terms
  logic signed [35:0] aap_r [3];
  logic signed [33:0] abp_r [3];
  logic signed [31:0] bbp_r [3];
  logic signed [37:0] atp_r [3];
  logic signed [35:0] btp_r [3];
  // S4: rounded dots
  logic signed [27:0] aa_r, ab_r, bb_r;
  logic signed [32:0] at_r, bt_r;
  // S5: 2x2 products
  logic signed [55:0] p1_r, p2_r;
  logic signed [60:0] p3_r, p4_r;
  // S6
  logic          rej_r;
  logic [NW-1:0] n_r;
  logic [DW-1:0] d_r;

  logic signed [15:0] f [3];
  logic signed [15:0] b [3];
  logic signed [15:0] rm [3][3];
  logic signed [19:0] t [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f[i]     = in_data[16*i +: 16];
      b[i]     = in_data[48 + 16*i +: 16];
      t[i]     = cfg.trans[20*i +: 20];
      rm[0][i] = cfg.rot0[16*i +: 16];
      rm[1][i] = cfg.rot1[16*i +: 16];
      rm[2][i] = cfg.rot2[16*i +: 16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_v};
    end
  end

  logic signed [33:0] s_rnd [3];
  logic signed [37:0] aa_s, ab_s, bb_s;
  logic signed [39:0] at_s, bt_s;
  logic signed [56:0] det;
  logic signed [61:0] num, num_abs;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s_rnd[i] = 34'(pr_r[i][0]) + 34'(pr_r[i][1]) + 34'(pr_r[i][2]) + 34'sd16384;
    end
    aa_s = 38'(aap_r[0]) + 38'(aap_r[1]) + 38'(aap_r[2]) + 38'sd512;
    ab_s = 38'(abp_r[0]) + 38'(abp_r[1]) + 38'(abp_r[2]) + 38'sd512;
    bb_s = 38'(bbp_r[0]) + 38'(bbp_r[1]) + 38'(bbp_r[2]) + 38'sd512;
    at_s = 40'(atp_r[0]) + 40'(atp_r[1]) + 40'(atp_r[2]) + 40'sd64;
    bt_s = 40'(btp_r[0]) + 40'(btp_r[1]) + 40'(btp_r[2]) + 40'sd64;
    det  = 57'(p1_r) - 57'(p2_r);
    num  = 62'(p3_r) - 62'(p4_r);
    num_abs = num[61] ? -num : num;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pr_r[i][j] <= rm[i][j] * f[j];
        end
        b1_r[i]  <= b[i];
        a_r[i]   <= s_rnd[i][32:15];
        b2_r[i]  <= b1_r[i];
        aap_r[i] <= a_r[i] * a_r[i];
        abp_r[i] <= a_r[i] * b2_r[i];
        bbp_r[i] <= b2_r[i] * b2_r[i];
        atp_r[i] <= a_r[i] * t[i];
        btp_r[i] <= b2_r[i] * t[i];
      end
      aa_r  <= aa_s[37:10];
      ab_r  <= ab_s[37:10];
      bb_r  <= bb_s[37:10];
      at_r  <= at_s[39:7];
      bt_r  <= bt_s[39:7];
      p1_r  <= aa_r * bb_r;
      p2_r  <= ab_r * ab_r;
      p3_r  <= bb_r * at_r;
      p4_r  <= ab_r * bt_r;
      rej_r <= (det <= 57'sd0) || (det < $signed({17'b0, cfg.thr, 8'b0}));
      n_r   <= num_abs[NW-1:0];
      d_r   <= det[DW-1:0];
    end
  end

  assign fo.valid  = v_r[5];
  assign fo.reject = rej_r;
  assign fo.n      = n_r;
  assign fo.d      = d_r;

endmodule

@@ hw/rtl/rdt_div.sv @@
module rdt_div import rdt_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  front_out_t    fo,
  output logic          res_v,
  output logic [QW-1:0] res_depth,
  output logic          res_ok
);

  logic    [DivStages:0] v_r;
  div_st_t               st_r [DivStages+1];
  div_st_t               init;

  // integer part of n/d first; it must fit 16 bits or the depth saturates
  always_comb begin
    init.reject = fo.reject;
    init.sat    = ({{(DW-NW+DepthFrac){1'b0}}, fo.n[NW-1:DepthFrac]} >= fo.d);
    init.r      = {{(DW-NW+DepthFrac){1'b0}}, fo.n[NW-1:DepthFrac]};
    init.nl     = {fo.n[DepthFrac-1:0], {(QW-DepthFrac){1'b0}}};
    init.q      = '0;
    init.d      = fo.d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[DivStages-1:0], fo.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= init;
      for (int k = 1; k <= DivStages; k++) begin
        st_r[k] <= div_step(st_r[k-1]);
      end
    end
  end

  assign res_v     = v_r[DivStages];
  assign res_ok    = !st_r[DivStages].reject;
  assign res_depth = st_r[DivStages].reject ? '0 :
                     st_r[DivStages].sat    ? '1 : st_r[DivStages].q;

endmodule

@@ hw/rtl/rdt_checker.sv @@
`include "assert_macros.svh"

module rdt_checker import rdt_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser,
  input logic        pready
);

  `RDT_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "out dropped")
  `RDT_ASSERT(a_out_stable, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser), "out changed")
  `RDT_ASSERT(a_reject_zero, clk, rst_n, out_tvalid && !out_tuser |-> out_tdata == 32'd0, "rejected pair with depth")
  `RDT_ASSERT(a_reset_empty, clk, rst_n, $past(!rst_n) |-> !out_tvalid, "output valid after reset")
  `RDT_ASSERT_ALWAYS(a_pready, clk, pready, "pready low")

endmodule

bind two_ray_depth_triangulation rdt_checker u_rdt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .pready     (pready)
);

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import rdt_pkg::*;

  // Depth result as the predictor sees it.
  typedef struct packed {
    logic [31:0] depth;
    logic        accepted;
  } depth_res_t;

  // Predicted results in acceptance order, plus the mismatch tally.
  class depth_scoreboard;
    depth_res_t  pending[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned rejects;
    int unsigned saturated;

    function void note_pair(depth_res_t r);
      pending.push_back(r);
    endfunction

    task check_result(logic [31:0] depth, logic acc);
      depth_res_t e;
      if (pending.size() == 0) begin
        report("result with no pair outstanding");
        return;
      end
      e = pending.pop_front();
      checked++;
      if (!acc) rejects++;
      if (acc && depth == 32'hFFFF_FFFF) saturated++;
      if (acc !== e.accepted)
        report($sformatf("flag got %0b want %0b", acc, e.accepted));
      if (depth !== e.depth)
        report($sformatf("depth got %h want %h", depth, e.depth));
    endtask

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;   // ref_x, ref_y, ref_z, cur_x, cur_y, cur_z, low up
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // depth_out
  logic        out_tuser;  // valid_res
  logic        psel, penable, pwrite;
  logic [CfgAw-1:0] paddr;
  logic [CfgDw-1:0] pwdata;
  logic [CfgDw-1:0] prdata;
  logic             pready;

  // Shadow copy of the programmed registers.
  logic [47:0] rot_sh[3];
  logic [59:0] trans_sh;
  logic [31:0] thr_sh;

  depth_scoreboard sb;
  int send_idle_pct;   // sender idle chance, percent
  int recv_stall_pct;  // receiver stall chance, percent

  two_ray_depth_triangulation DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Round v / 2^s half toward +inf (arithmetic shift floors, which is the same).
  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  // Predict one pair from the shadow registers.
  function automatic depth_res_t triangulate(logic [95:0] pair);
    longint f[3], b[3], a[3], t[3];
    longint aa, ab, bb, at, bt, det, num, sum;
    logic [63:0] n, d;
    depth_res_t res;
    aa = 0; ab = 0; bb = 0; at = 0; bt = 0;
    for (int i = 0; i < 3; i++) begin
      f[i] = longint'($signed(pair[16*i +: 16]));
      b[i] = longint'($signed(pair[48 + 16*i +: 16]));
      t[i] = longint'($signed(trans_sh[20*i +: 20]));
    end
    for (int i = 0; i < 3; i++) begin
      sum = 0;
      for (int j = 0; j < 3; j++)
        sum += longint'($signed(rot_sh[i][16*j +: 16])) * f[j];
      a[i] = rnd_shift(sum, 15);
    end
    for (int i = 0; i < 3; i++) begin
      aa += a[i] * a[i];
      ab += a[i] * b[i];
      bb += b[i] * b[i];
      at += a[i] * t[i];
      bt += b[i] * t[i];
    end
    aa = rnd_shift(aa, 10);
    ab = rnd_shift(ab, 10);
    bb = rnd_shift(bb, 10);
    at = rnd_shift(at, 7);
    bt = rnd_shift(bt, 7);
    det = aa * bb - ab * ab;
    res = '0;
    if (det <= 0 || det < (longint'(thr_sh) << 8)) return res;
    num = bb * at - ab * bt;
    n = (num < 0) ? 64'(-num) : 64'(num);
    d = 64'(det);
    res.accepted = 1'b1;
    // |num| < 2^56 so n*2^16 fits in 128 bits; do the division wide.
    if (n / d >= 64'h1_0000) res.depth = 32'hFFFF_FFFF;
    else res.depth = 32'(({64'd0, n} << 16) / {64'd0, d});
    return res;
  endfunction

  // APB write: setup then access cycle; the caller closes the last transfer.
  task automatic reg_write(logic [RegIdxW-1:0] idx, logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CfgAw'(8 * idx);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_ROT0:  rot_sh[0] = val[47:0];
      REG_ROT1:  rot_sh[1] = val[47:0];
      REG_ROT2:  rot_sh[2] = val[47:0];
      REG_TRANS: trans_sh  = val[59:0];
      default:   thr_sh    = val[31:0];
    endcase
  endtask

  task automatic program_all(logic [47:0] r0, logic [47:0] r1, logic [47:0] r2,
                             logic [59:0] tr, logic [31:0] th);
    reg_write(REG_ROT0, 64'(r0));
    reg_write(REG_ROT1, 64'(r1));
    reg_write(REG_ROT2, 64'(r2));
    reg_write(REG_TRANS, 64'(tr));
    reg_write(REG_THR, 64'(th));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Push one pair; the prediction is logged at the accepting edge.
  task automatic send_pair(logic [95:0] pair);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pair;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_pair(triangulate(pair));
  endtask

  task automatic idle_input();
    in_tvalid <= 1'b0;
  endtask

  // Wait for the pipe to drain, with a bound.
  task automatic drain();
    int guard;
    idle_input();
    guard = 0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
  endtask

  // Random Q1.15 value biased toward the extremes, zero and small magnitudes.
  function automatic logic [15:0] rnd_q15();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(2000)) - 1000);
      default: return 16'($urandom);
    endcase
  endfunction

  // Bearings from rnd_q15 components, a quarter fully random; half of the rest get a large positive z.
  function automatic logic [95:0] rnd_pair();
    logic [95:0] p;
    if ($urandom_range(3) == 0) begin
      p = {$urandom, $urandom, $urandom};
    end else begin
      for (int i = 0; i < 6; i++) p[16*i +: 16] = rnd_q15();
      if ($urandom_range(1)) begin
        p[32 +: 16] = 16'($urandom_range(32767, 16384));
        p[80 +: 16] = 16'($urandom_range(32767, 16384));
      end
    end
    return p;
  endfunction

  function automatic logic [47:0] rnd_row();
    return {rnd_q15(), rnd_q15(), rnd_q15()};
  endfunction

  // Receiver: stalls at the current phase's rate, checks on each handshake.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    sb = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    rot_sh[0]  = ROT0_RST;
    rot_sh[1]  = ROT1_RST;
    rot_sh[2]  = ROT2_RST;
    trans_sh   = '0;
    thr_sh     = THR_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset config (signed permutation rotation, zero translation -> depth 0 or reject).
    send_pair({16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000});
    send_pair({16'h7FFF, 16'h4000, 16'h0000, 16'h7FFF, 16'h0000, 16'h4000});
    drain();

    // Directed: sideways baseline so depths are meaningful.
    program_all(ROT0_RST, ROT1_RST, ROT2_RST,
                {20'd0, 20'd0, 20'h01000}, THR_RST);
    send_pair({16'h7FFF, 16'h0000, 16'h0800, 16'h7FFF, 16'h0000, 16'h0000});
    send_pair({16'h7FFF, 16'h0000, 16'h0010, 16'h7FFF, 16'h0000, 16'h0000});
    // Parallel rays: singular matrix, rejected.
    send_pair({16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000});
    // Nearly parallel: tiny det, huge depth or reject.
    send_pair({16'h7FFF, 16'h0000, 16'h0001, 16'h7FFF, 16'h0000, 16'h0000});
    send_pair({16'h7FFF, 16'h0002, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000});
    // Full-scale codes.
    send_pair({16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000});
    send_pair({16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
    send_pair({16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000});
    send_pair('0);
    send_pair({96{1'b1}});
    drain();

    // Extreme config: full-scale rotation, translation extremes, zero threshold.
    program_all({3{16'h8000}}, {3{16'h7FFF}}, {16'h8000, 16'h7FFF, 16'h8000},
                {20'h80000, 20'h7FFFF, 20'h80000}, 32'd0);
    for (int i = 0; i < 8; i++) send_pair(rnd_pair());
    drain();
    program_all({3{16'hFFFF}}, 48'h0, {3{16'h7FFF}}, {60{1'b1}}, 32'hFFFF_FFFF);
    for (int i = 0; i < 4; i++) send_pair(rnd_pair());
    drain();

    // Random phases: each idling mix, each with a fresh configuration.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      if (ph == 0)
        program_all(ROT0_RST, ROT1_RST, ROT2_RST,
                    {20'h00400, 20'hFFC00, 20'h02000}, THR_RST);
      else
        program_all(rnd_row(), rnd_row(), rnd_row(),
                    60'({$urandom, $urandom}), ($urandom_range(3) == 0) ? $urandom
                                          : 32'($urandom_range(50000)));
      for (int i = 0; i < 75; i++) send_pair(rnd_pair());
      drain();
    end

    $display("covered %0d results (%0d rejected, %0d saturated) over 12 settings",
             sb.checked, sb.rejects, sb.saturated);
    $display("and four idling mixes on both channels");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/rdt_pkg.sv
hw/rtl/rdt_regs.sv
hw/rtl/rdt_front.sv
hw/rtl/rdt_div.sv
hw/rtl/two_ray_depth_triangulation.sv
hw/rtl/rdt_checker.sv
sim/tb_top.sv
